// ----- design/tclp_pkg.sv -----
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types and constants for the text command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

    typedef enum logic [2:0] {
        KIND_START        = 3'd0,
        KIND_STOP         = 3'd1,
        KIND_SET_SPEED    = 3'd2,
        KIND_UNRECOGNISED = 3'd3,
        KIND_OVERFLOW     = 3'd4
    } cmd_kind_t;

    typedef enum logic [2:0] {
        PH_SKIP    = 3'b001,
        PH_DIGITS  = 3'b010,
        PH_STOPPED = 3'b100
    } num_phase_t;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [3:0] PROG_FROZEN = 4'd15;
    localparam logic [3:0] START_LEN   = 4'd5;
    localparam logic [3:0] STOP_LEN    = 4'd4;
    localparam logic [3:0] SET_LEN     = 4'd10;

    localparam logic [2:0] ALIVE_ALL = 3'b111;

    localparam logic [31:0] ACC_CAP   = 32'h8000_0000;
    localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [3:0]  progress;
        logic [2:0]  alive;
        logic        pending_cr;
        num_phase_t  phase;
        logic        negative;
        logic [31:0] acc;
    } parse_state_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] speed;
    } result_t;

    localparam parse_state_t STATE_CLEAR = '{
        progress:   4'd0,
        alive:      ALIVE_ALL,
        pending_cr: 1'b0,
        phase:      PH_SKIP,
        negative:   1'b0,
        acc:        32'd0
    };

    function automatic logic [7:0] kw_start_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = "S";
            4'd1:    ch = "T";
            4'd2:    ch = "A";
            4'd3:    ch = "R";
            4'd4:    ch = "T";
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_stop_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = "S";
            4'd1:    ch = "T";
            4'd2:    ch = "O";
            4'd3:    ch = "P";
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_set_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = "S";
            4'd1:    ch = "E";
            4'd2:    ch = "T";
            4'd3:    ch = CHAR_SPACE;
            4'd4:    ch = "S";
            4'd5:    ch = "P";
            4'd6:    ch = "E";
            4'd7:    ch = "E";
            4'd8:    ch = "D";
            4'd9:    ch = CHAR_SPACE;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/tclp_in_reg.sv -----
// ----------------------------------------------------------------------------
// tclp_in_reg
// Input register: captures one received byte per transaction.
// ----------------------------------------------------------------------------
module tclp_in_reg
    import tclp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,
    output logic       rx_stall,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign rx_stall   = valid_reg && !advance;
    assign take       = rx_valid && !rx_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// ----- design/tclp_engine.sv -----
// ----------------------------------------------------------------------------
// tclp_engine
// Line state and incremental keyword/number matcher, one byte per advance.
// ----------------------------------------------------------------------------
module tclp_engine
    import tclp_pkg::*;
#(
    parameter int LINE_BYTES = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] item_byte,
    output logic       has_result,
    output result_t    result
);

    localparam int LPW = $clog2(LINE_BYTES);
    localparam logic [LPW-1:0] POS_LAST = LPW'(LINE_BYTES - 1);

    logic [LPW-1:0] line_pos_reg;
    logic [LPW-1:0] line_pos_next;
    parse_state_t   state_reg;
    parse_state_t   state_next;
    parse_state_t   after_cr;
    parse_state_t   fed;
    logic           is_nl;
    logic           is_over;
    logic           frozen;

    function automatic parse_state_t number_feed(input parse_state_t s, input logic [7:0] c);
        parse_state_t n;
        logic         digit;
        logic         space;
        logic [35:0]  v;
        n     = s;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        v     = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {32'd0, c[3:0]};
        unique case (s.phase)
            PH_SKIP:
            begin
                if (!space)
                begin
                    if (c == CHAR_PLUS)
                    begin
                        n.phase = PH_DIGITS;
                    end
                    else if (c == CHAR_MINUS)
                    begin
                        n.negative = 1'b1;
                        n.phase    = PH_DIGITS;
                    end
                    else if (digit)
                    begin
                        n.acc   = {28'd0, c[3:0]};
                        n.phase = PH_DIGITS;
                    end
                    else
                    begin
                        n.phase = PH_STOPPED;
                    end
                end
            end
            PH_DIGITS:
            begin
                if (digit)
                begin
                    n.acc = (v > {4'd0, ACC_CAP}) ? ACC_CAP : v[31:0];
                end
                else
                begin
                    n.phase = PH_STOPPED;
                end
            end
            PH_STOPPED:
            begin
            end
            default:
            begin
                n.phase = PH_STOPPED;
            end
        endcase
        return n;
    endfunction

    function automatic parse_state_t match_feed(input parse_state_t s, input logic [7:0] c);
        parse_state_t n;
        logic [2:0]   keep;
        n    = s;
        keep = 3'b000;
        if (s.progress == PROG_FROZEN)
        begin
            n = s;
        end
        else if (c == CHAR_NUL)
        begin
            keep[0] = s.alive[0] && (s.progress == START_LEN);
            keep[1] = s.alive[1] && (s.progress == STOP_LEN);
            keep[2] = s.alive[2] && (s.progress >= SET_LEN);
            if (keep[2])
            begin
                n.phase = PH_STOPPED;
            end
            n.alive    = keep;
            n.progress = PROG_FROZEN;
        end
        else if (s.progress >= SET_LEN)
        begin
            if (s.alive[2])
            begin
                n = number_feed(s, c);
            end
        end
        else
        begin
            if (s.progress >= START_LEN || c != kw_start_char(s.progress))
            begin
                n.alive[0] = 1'b0;
            end
            if (s.progress >= STOP_LEN || c != kw_stop_char(s.progress))
            begin
                n.alive[1] = 1'b0;
            end
            if (c != kw_set_char(s.progress))
            begin
                n.alive[2] = 1'b0;
            end
            n.progress = s.progress + 4'd1;
        end
        return n;
    endfunction

    assign is_nl   = (item_byte == CHAR_NL);
    assign is_over = (line_pos_reg >= POS_LAST);
    assign frozen  = (state_reg.progress == PROG_FROZEN);

    always_comb
    begin
        after_cr = state_reg.pending_cr ? match_feed(state_reg, CHAR_CR) : state_reg;
        if (item_byte == CHAR_CR)
        begin
            fed            = after_cr;
            fed.pending_cr = 1'b1;
        end
        else
        begin
            fed            = match_feed(after_cr, item_byte);
            fed.pending_cr = 1'b0;
        end
    end

    always_comb
    begin
        result.kind  = KIND_UNRECOGNISED;
        result.speed = '0;
        if (is_nl)
        begin
            if (state_reg.alive[0] && (frozen || state_reg.progress == START_LEN))
            begin
                result.kind = KIND_START;
            end
            else if (state_reg.alive[1] && (frozen || state_reg.progress == STOP_LEN))
            begin
                result.kind = KIND_STOP;
            end
            else if (state_reg.alive[2] && (frozen || state_reg.progress >= SET_LEN))
            begin
                result.kind = KIND_SET_SPEED;
                if (state_reg.negative)
                begin
                    result.speed = 32'd0 - state_reg.acc;
                end
                else
                begin
                    result.speed = state_reg.acc[31] ? SPEED_MAX : state_reg.acc;
                end
            end
        end
        else
        begin
            result.kind = KIND_OVERFLOW;
        end
    end

    assign has_result = is_nl || is_over;

    always_comb
    begin
        if (has_result)
        begin
            state_next    = STATE_CLEAR;
            line_pos_next = '0;
        end
        else
        begin
            state_next    = fed;
            line_pos_next = line_pos_reg + LPW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= STATE_CLEAR;
            line_pos_reg <= '0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            line_pos_reg <= line_pos_next;
        end
    end

endmodule

// ----- design/tclp_out_reg.sv -----
// ----------------------------------------------------------------------------
// tclp_out_reg
// Result register: holds one classified line until the transaction completes.
// ----------------------------------------------------------------------------
module tclp_out_reg
    import tclp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    cmd_stall,
    output logic    free,
    output logic    cmd_valid,
    output result_t held
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || !cmd_stall;
    assign valid_next = load || (valid_reg && cmd_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign cmd_valid = valid_reg;
    assign held      = result_reg;

endmodule

// ----- design/text_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// text_command_line_parser
// Gathers received bytes into lines and classifies each finished line.
//
//   channel   direction   payload                        handshake
//   rx        in          rx_byte                        rx_valid / rx_stall
//   cmd       out         command_kind, speed_value      cmd_valid / cmd_stall
//
// One byte per cycle sustained while cmd_stall does not back up into rx_stall;
// a result reaches the ports through the input register, then the matcher
// into the result register, once the newline (or the overflowing byte) is taken.
// Reset clears the line state and both valid flags.
// cmd_stall holds the result register and backs up into rx_stall only when
// a further result is ready to be written.
// ----------------------------------------------------------------------------
module text_command_line_parser
    import tclp_pkg::*;
#(
    parameter int LINE_BYTES = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               cmd_valid,
    input  logic               cmd_stall,
    output logic [2:0]         command_kind,
    output logic signed [31:0] speed_value
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       advance;
    logic       has_result;
    logic       free;
    result_t    result;
    result_t    held;

    assign advance = item_valid && (free || !has_result);

    tclp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_byte    (rx_byte),
        .rx_stall   (rx_stall),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    tclp_engine #(
        .LINE_BYTES (LINE_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_byte  (item_byte),
        .has_result (has_result),
        .result     (result)
    );

    tclp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .result    (result),
        .cmd_stall (cmd_stall),
        .free      (free),
        .cmd_valid (cmd_valid),
        .held      (held)
    );

    assign command_kind = held.kind;
    assign speed_value  = held.speed;

endmodule

// ----- design/tclp_checker.sv -----
// ----------------------------------------------------------------------------
// tclp_checker
// Port-level checks on the text command line parser.
// ----------------------------------------------------------------------------
module tclp_checker
    import tclp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rx_valid,
    input logic               rx_stall,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input logic [2:0]         command_kind,
    input logic signed [31:0] speed_value
);

    a_kind_range : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (command_kind <= KIND_OVERFLOW))
        else $error("command kind out of range");

    a_speed_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && command_kind != KIND_SET_SPEED) |-> (speed_value == 32'sd0))
        else $error("speed not zero for a non set speed result");

    a_rx_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> (cmd_valid && cmd_stall))
        else $error("input stalled without a held result");

    a_result_origin : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_valid) |-> $past(rx_valid && !rx_stall, 2))
        else $error("result without an accepted byte");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_stall) |=> (cmd_valid && $stable(command_kind)))
        else $error("stalled result changed");

endmodule

bind text_command_line_parser tclp_checker u_tclp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command_kind (command_kind),
    .speed_value  (speed_value)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text command line parser.
//
// Feeds byte streams made of command lines: keywords, speed settings with
// signs, blanks and out-of-range values, near misses, embedded NUL and
// carriage return bytes, raw noise and lines long enough to overflow.
// A software copy of the line parser predicts each result as the byte is
// taken, and a sink with random stall compares every result with the
// oldest prediction. Both sides idle at random, except for one steady
// stretch.
// ----------------------------------------------------------------------------
module tb_top
    import tclp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN     = 128;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BYTES = 1000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               rx_valid  = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte   = 8'd0;
    logic               cmd_valid;
    logic               cmd_stall = 1'b0;
    logic [2:0]         command_kind;
    logic signed [31:0] speed_value;

    result_t expected_cmds[$];
    int      mismatches  = 0;
    int      cycle_count = 0;
    int      bytes_sent  = 0;
    logic    no_idle     = 1'b0;

    int          line_pos;
    logic [3:0]  prog;
    logic [2:0]  alive;
    logic        pend_cr;
    num_phase_t  phase;
    logic        negative;
    logic [31:0] acc;

    string kw_start_txt = "START";
    string kw_stop_txt  = "STOP";
    string kw_set_txt   = "SET SPEED ";

    text_command_line_parser #(
        .LINE_BYTES(LINE_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .command_kind(command_kind),
        .speed_value(speed_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------
    function automatic void clear_line();
        line_pos = 0;
        prog     = 4'd0;
        alive    = 3'b111;
        pend_cr  = 1'b0;
        phase    = PH_SKIP;
        negative = 1'b0;
        acc      = 32'd0;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void accumulate_number(logic [7:0] c);
        logic        digit;
        logic [63:0] wide;
        digit = c >= CHAR_ZERO && c <= CHAR_NINE;
        if (phase == PH_SKIP)
        begin
            if (!is_blank(c))
            begin
                if (c == CHAR_PLUS)
                    phase = PH_DIGITS;
                else if (c == CHAR_MINUS)
                begin
                    negative = 1'b1;
                    phase    = PH_DIGITS;
                end
                else if (digit)
                begin
                    acc   = 32'(c - CHAR_ZERO);
                    phase = PH_DIGITS;
                end
                else
                    phase = PH_STOPPED;
            end
        end
        else if (phase == PH_DIGITS)
        begin
            if (digit)
            begin
                wide = 64'(acc) * 64'd10 + 64'(c - CHAR_ZERO);
                acc  = (wide > 64'(ACC_CAP)) ? ACC_CAP : wide[31:0];
            end
            else
                phase = PH_STOPPED;
        end
    endfunction

    function automatic void match_keywords(logic [7:0] c);
        logic [3:0] p;
        logic [2:0] keep;
        p = prog;
        if (p == PROG_FROZEN)
            return;
        if (c == CHAR_NUL)
        begin
            keep = 3'b000;
            if (alive[0] && p == START_LEN)
                keep[0] = 1'b1;
            if (alive[1] && p == STOP_LEN)
                keep[1] = 1'b1;
            if (alive[2] && p >= SET_LEN)
            begin
                keep[2] = 1'b1;
                phase   = PH_STOPPED;
            end
            alive = keep;
            prog  = PROG_FROZEN;
            return;
        end
        if (p >= SET_LEN)
        begin
            if (alive[2])
                accumulate_number(c);
            return;
        end
        if (alive[0] && (p >= START_LEN || c != kw_start_txt[p]))
            alive[0] = 1'b0;
        if (alive[1] && (p >= STOP_LEN || c != kw_stop_txt[p]))
            alive[1] = 1'b0;
        if (alive[2] && c != kw_set_txt[p])
            alive[2] = 1'b0;
        prog = p + 4'd1;
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        result_t    res;
        logic       frozen;
        res.kind  = KIND_UNRECOGNISED;
        res.speed = 32'sd0;
        if (c == CHAR_NL)
        begin
            frozen = prog == PROG_FROZEN;
            if (alive[0] && (frozen || prog == START_LEN))
                res.kind = KIND_START;
            else if (alive[1] && (frozen || prog == STOP_LEN))
                res.kind = KIND_STOP;
            else if (alive[2] && (frozen || prog >= SET_LEN))
            begin
                res.kind = KIND_SET_SPEED;
                if (negative)
                    res.speed = 32'd0 - acc;
                else
                    res.speed = (acc > SPEED_MAX) ? SPEED_MAX : acc;
            end
            expected_cmds.push_back(res);
            clear_line();
            return;
        end
        if (line_pos >= LINE_LEN - 1)
        begin
            clear_line();
            res.kind = KIND_OVERFLOW;
            expected_cmds.push_back(res);
            return;
        end
        line_pos++;
        if (pend_cr)
            match_keywords(CHAR_CR);
        if (c == CHAR_CR)
            pend_cr = 1'b1;
        else
        begin
            pend_cr = 1'b0;
            match_keywords(c);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 35)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // ------------------------------------------------------------------
    // Result sink
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (expected_cmds.size() == 0)
                note_mismatch("unexpected transaction, kind", -1, int'(command_kind));
            else
            begin
                want = expected_cmds.pop_front();
                if (command_kind !== want.kind)
                    note_mismatch("command_kind", int'(want.kind), int'(command_kind));
                if (speed_value !== want.speed)
                    note_mismatch("speed_value", want.speed, speed_value);
            end
        end
        cmd_stall <= !no_idle && $urandom_range(0, 99) < 35;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_keywords();
        send_text("START\n");
        send_text("STOP\n");
        send_text("START\r\n");
        send_text("STOP\r\n");
        send_text("STAR\n");
        send_text("STARTX\n");
        send_text("\n");
        send_text("\r\n");
        send_text("START\r\r\n");
        send_text("ST\rOP\n");
    endtask

    task automatic test_speed_values();
        send_text("SET SPEED 42\n");
        send_text("SET SPEED -17\r\n");
        send_text("SET SPEED  \t+2147483647\n");
        send_text("SET SPEED 2147483648\n");
        send_text("SET SPEED -2147483648\n");
        send_text("SET SPEED -99999999999\n");
        send_text("SET SPEED \n");
        send_text("SET SPEED abc\n");
        send_text("SET SPEED 12x34\n");
        send_text("SET SPEED\n");
    endtask

    task automatic test_zero_bytes();
        send_text("START");
        send_byte(CHAR_NUL);
        send_text("junk\n");
        send_text("SET SPEED 5");
        send_byte(CHAR_NUL);
        send_text("7\n");
        send_byte(CHAR_NUL);
        send_byte(CHAR_NL);
        send_byte(8'hFF);
        send_byte(CHAR_NL);
    endtask

    task automatic test_line_overflow();
        repeat (LINE_LEN - 1)
            send_byte("A");
        send_byte(CHAR_NL);
        repeat (LINE_LEN)
            send_byte("B");
        send_byte(CHAR_NL);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CHAR_TAB;
            1:       return 8'd11;
            2:       return 8'd12;
            3:       return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic string pick_keyword();
        case ($urandom_range(0, 2))
            0:       return kw_start_txt;
            1:       return kw_stop_txt;
            default: return kw_set_txt;
        endcase
    endfunction

    task automatic send_number_text();
        int sel;
        int n_digits;
        repeat ($urandom_range(0, 3))
            send_byte(pick_blank());
        sel = $urandom_range(0, 9);
        if (sel < 3)
            send_byte(CHAR_MINUS);
        else if (sel < 5)
            send_byte(CHAR_PLUS);
        else if (sel == 5)
            send_text("+-");
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            send_text("21474836");
            repeat (2)
                send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        else
        begin
            n_digits = (sel < 30) ? $urandom_range(10, 14) : $urandom_range(0, 6);
            repeat (n_digits)
                send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0)
            send_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic send_random_line();
        string kw;
        int    sel;
        int    cut;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            send_text(kw_start_txt);
        else if (sel < 30)
            send_text(kw_stop_txt);
        else if (sel < 60)
        begin
            send_text(kw_set_txt);
            send_number_text();
        end
        else if (sel < 75)
        begin
            kw  = pick_keyword();
            cut = $urandom_range(0, kw.len());
            for (int i = 0; i < kw.len(); i++)
            begin
                if (i == cut && $urandom_range(0, 1) == 0)
                    break;
                send_byte(i == cut ? 8'($urandom_range(0, 255)) : kw[i]);
            end
            if ($urandom_range(0, 2) == 0)
                send_byte(8'($urandom_range(32, 126)));
        end
        else if (sel < 85)
        begin
            repeat ($urandom_range(0, 20))
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (sel < 92)
        begin
            kw  = pick_keyword();
            cut = $urandom_range(0, kw.len());
            for (int i = 0; i < cut; i++)
                send_byte(kw[i]);
            send_byte(CHAR_NUL);
            repeat ($urandom_range(0, 4))
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (sel < 98)
        begin
            kw  = pick_keyword();
            cut = $urandom_range(0, kw.len() - 1);
            for (int i = 0; i < kw.len(); i++)
            begin
                if (i == cut)
                    send_byte(CHAR_CR);
                send_byte(kw[i]);
            end
        end
        else
        begin
            repeat ($urandom_range(LINE_LEN - 8, LINE_LEN + 12))
                send_byte(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(0, 3) == 0)
            send_byte(CHAR_CR);
        send_byte(CHAR_NL);
    endtask

    task automatic test_random_lines();
        int first;
        first = bytes_sent;
        while (bytes_sent < first + RANDOM_BYTES)
        begin
            no_idle = (bytes_sent >= first + 500) && (bytes_sent < first + 800);
            send_random_line();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_line();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keywords();
        test_speed_values();
        test_zero_bytes();
        test_line_overflow();
        test_random_lines();
        rx_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- text_command_line_parser.f -----
design/tclp_pkg.sv
design/tclp_in_reg.sv
design/tclp_engine.sv
design/tclp_out_reg.sv
design/text_command_line_parser.sv
design/tclp_checker.sv
bench/tb_top.sv
